[src/olidf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olidf_pkg
// Shared constants, codes and types for the positional ordered list.
// ----------------------------------------------------------------------------
package olidf_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LEN_W   = $clog2(DEPTH + 1);
  localparam int FLD_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CMP_W   = ((LEN_W > FLD_W) ? LEN_W : FLD_W) + 1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic shift_in;
    logic shift_out;
    logic cmp;
    logic live;
  } cell_ctl_t;

endpackage

[src/olidf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olidf_if
// Valid/ready channels for list operations and their results.
// ----------------------------------------------------------------------------
interface olidf_in_if;
  import olidf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [FLD_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface olidf_out_if;
  import olidf_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [FLD_W-1:0] match_position;
  logic [FLD_W-1:0] list_length;
  logic             last;

  modport source (output valid, status, match_position, list_length, last, input ready);
  modport sink   (input valid, status, match_position, list_length, last, output ready);
endinterface

[src/olidf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olidf_cell
// One list slot: holds an entry, shifts with its neighbors, flags a match.
// ----------------------------------------------------------------------------
module olidf_cell (
  input  logic                              clk,
  input  olidf_pkg::cell_ctl_t              ctl,
  input  logic signed [olidf_pkg::VAL_W-1:0] din,
  input  logic signed [olidf_pkg::VAL_W-1:0] left_entry,
  input  logic signed [olidf_pkg::VAL_W-1:0] right_entry,
  output logic signed [olidf_pkg::VAL_W-1:0] entry,
  output logic                              match
);
  import olidf_pkg::*;

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  logic                    match_r, match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = din;
    end else if (ctl.shift_in) begin
      entry_nxt = left_entry;
    end else if (ctl.shift_out) begin
      entry_nxt = right_entry;
    end
    match_nxt = match_r;
    if (ctl.cmp) begin
      match_nxt = ctl.live && (entry_r == din);
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

[src/ordered_list_insert_delete_find.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_find
// Positional ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Insert and delete are applied in their accept cycle: every cell loads, keeps
// or takes its left or right neighbor's entry in the same clock and one result
// follows. A find compares all cells in its accept cycle, then walks the match
// flags one position per cycle while the output is not stalled, giving one
// transaction per match (last on the final one) or one not-found transaction.
// One operation is in work at a time; a new one is taken only when the output
// register is empty or is being drained in that same cycle.
module ordered_list_insert_delete_find (
  input  logic         clk,
  input  logic         rst_n,
  olidf_in_if.sink     in_chan,
  olidf_out_if.source  out_chan
);
  import olidf_pkg::*;

  state_t               state_r, state_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;

  logic                 ov_r, ov_nxt;
  status_t              status_r, status_nxt;
  logic [FLD_W-1:0]     mpos_r, mpos_nxt;
  logic [FLD_W-1:0]     olen_r, olen_nxt;
  logic                 olast_r, olast_nxt;

  logic                 out_free, in_ready, in_fire, scan_step;
  logic                 is_ins, is_del, is_find;
  logic [FLD_W-1:0]     slot;
  logic [CMP_W-1:0]     slot_x, pos_x, len_x;
  logic                 ins_bad, full, del_bad, ins_ok, del_ok;

  logic [DEPTH-1:0]     match_vec, rest_vec;
  logic [IDX_W:0]       kp1;
  logic                 cur_match, rest_zero;

  logic signed [VAL_W-1:0] entry_w [DEPTH];
  cell_ctl_t               ctl_w   [DEPTH];

  assign out_free = !ov_r || out_chan.ready;
  assign in_fire  = in_chan.valid && in_ready;

  assign is_ins  = (in_chan.mode == MODE_INSERT);
  assign is_del  = (in_chan.mode == MODE_DELETE);
  assign is_find = (in_chan.mode == MODE_FIND);

  assign slot    = (in_chan.position <= FLD_W'(1)) ? '0 : in_chan.position - FLD_W'(1);
  assign slot_x  = CMP_W'(slot);
  assign pos_x   = CMP_W'(in_chan.position);
  assign len_x   = CMP_W'(len_r);
  assign ins_bad = slot_x > len_x;
  assign full    = (len_x == CMP_W'(DEPTH));
  assign del_bad = (in_chan.position == '0) || (pos_x > len_x);
  assign ins_ok  = in_fire && is_ins && !ins_bad && !full;
  assign del_ok  = in_fire && is_del && !del_bad;

  assign kp1       = {1'b0, k_r} + (IDX_W+1)'(1);
  assign rest_vec  = match_vec & ({DEPTH{1'b1}} << kp1);
  assign rest_zero = (rest_vec == '0);
  assign cur_match = match_vec[k_r];

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CMP_W-1:0] idx_x;
    assign idx_x = CMP_W'(i);

    always_comb begin
      ctl_w[i].load      = ins_ok && (idx_x == slot_x);
      ctl_w[i].shift_in  = ins_ok && (idx_x > slot_x) && (idx_x <= len_x);
      ctl_w[i].shift_out = del_ok && (idx_x >= pos_x - CMP_W'(1)) &&
                           (idx_x + CMP_W'(1) < len_x);
      ctl_w[i].cmp       = in_fire && is_find;
      ctl_w[i].live      = idx_x < len_x;
    end

    logic signed [VAL_W-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = entry_w[i+1];
    end

    olidf_cell u_cell (
      .clk         (clk),
      .ctl         (ctl_w[i]),
      .din         (in_chan.value),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (entry_w[i]),
      .match       (match_vec[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && is_find) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (out_free && rest_zero) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready  = 1'b0;
    scan_step = 1'b0;
    case (state_r)
      S_IDLE:  in_ready  = out_free;
      S_SCAN:  scan_step = out_free;
      default: in_ready  = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    len_nxt    = len_r;
    k_nxt      = k_r;
    ov_nxt     = ov_r && !out_chan.ready;
    status_nxt = status_r;
    mpos_nxt   = mpos_r;
    olen_nxt   = olen_r;
    olast_nxt  = olast_r;

    if (ins_ok) begin
      len_nxt = len_r + LEN_W'(1);
    end else if (del_ok) begin
      len_nxt = len_r - LEN_W'(1);
    end

    if (in_fire) begin
      k_nxt = '0;
      if (!is_find) begin
        ov_nxt    = 1'b1;
        mpos_nxt  = '0;
        olast_nxt = 1'b1;
        olen_nxt  = FLD_W'(len_nxt);
        if (is_ins) begin
          status_nxt = ins_bad ? ST_BADPOS : (full ? ST_FULL : ST_OK);
        end else if (is_del) begin
          status_nxt = del_bad ? ST_BADPOS : ST_OK;
        end else begin
          status_nxt = ST_BADPOS;
        end
      end
    end

    if (scan_step) begin
      if (cur_match) begin
        ov_nxt     = 1'b1;
        status_nxt = ST_OK;
        mpos_nxt   = FLD_W'(kp1);
        olen_nxt   = FLD_W'(len_r);
        olast_nxt  = rest_zero;
        k_nxt      = kp1[IDX_W-1:0];
      end else if (rest_zero) begin
        ov_nxt     = 1'b1;
        status_nxt = ST_NOTFOUND;
        mpos_nxt   = '0;
        olen_nxt   = FLD_W'(len_r);
        olast_nxt  = 1'b1;
      end else begin
        k_nxt = kp1[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    status_r <= status_nxt;
    mpos_r   <= mpos_nxt;
    olen_r   <= olen_nxt;
    olast_r  <= olast_nxt;
  end

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = ov_r;
  assign out_chan.status         = status_r;
  assign out_chan.match_position = mpos_r;
  assign out_chan.list_length    = olen_r;
  assign out_chan.last           = olast_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(DEPTH))
    else $error("list length above capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (ov_r || state_r == S_SCAN))
    else $error("accepted transaction produced no result or scan");

  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !in_chan.ready)
    else $error("input accepted during find scan");

  a_nonfinal_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !olast_r) |-> (state_r == S_SCAN && status_r == ST_OK))
    else $error("non-final result outside find scan");

  a_len_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> $stable(len_r))
    else $error("length changed during find scan");

endmodule

[verif/olidf_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olidf_tb_pkg
// List scoreboard: shadows the ordered list and checks every result
// transaction against the results queued for each accepted operation.
// ----------------------------------------------------------------------------
package olidf_tb_pkg;

  import olidf_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    status_t          status;
    logic [FLD_W-1:0] match_position;
    logic [FLD_W-1:0] list_length;
    logic             last;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] shadow_list [DEPTH];
    int unsigned             shadow_len;
    list_result_t            expected_results [$];
    int unsigned             errors;

    function new();
      shadow_len = 0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void push_result(status_t st, int unsigned pos, logic fin);
      list_result_t r;
      r.status         = st;
      r.match_position = pos[FLD_W-1:0];
      r.list_length    = shadow_len[FLD_W-1:0];
      r.last           = fin;
      expected_results.push_back(r);
    endfunction

    // Applies one accepted operation to the shadow list and queues its results.
    function void note_op(logic [1:0] mode, logic [FLD_W-1:0] position,
                          logic signed [VAL_W-1:0] value);
      int unsigned slot;
      int unsigned k;
      int unsigned hits [$];
      case (mode)
        MODE_INSERT: begin
          slot = (position <= 1) ? 0 : position - 1;
          if (slot > shadow_len) begin
            push_result(ST_BADPOS, 0, 1'b1);
          end else if (shadow_len >= DEPTH) begin
            push_result(ST_FULL, 0, 1'b1);
          end else begin
            for (k = shadow_len; k > slot; k--) shadow_list[k] = shadow_list[k-1];
            shadow_list[slot] = value;
            shadow_len++;
            push_result(ST_OK, 0, 1'b1);
          end
        end
        MODE_DELETE: begin
          if (position < 1 || position > shadow_len) begin
            push_result(ST_BADPOS, 0, 1'b1);
          end else begin
            for (k = position - 1; k + 1 < shadow_len; k++)
              shadow_list[k] = shadow_list[k+1];
            shadow_len--;
            push_result(ST_OK, 0, 1'b1);
          end
        end
        MODE_FIND: begin
          for (k = 0; k < shadow_len; k++)
            if (shadow_list[k] == value) hits.push_back(k + 1);
          if (hits.size() == 0) begin
            push_result(ST_NOTFOUND, 0, 1'b1);
          end else begin
            for (k = 0; k < hits.size(); k++)
              push_result(ST_OK, hits[k], k + 1 == hits.size());
          end
        end
        default: push_result(ST_BADPOS, 0, 1'b1);
      endcase
    endfunction

    function void check_result(logic [1:0] status, logic [FLD_W-1:0] match_position,
                               logic [FLD_W-1:0] list_length, logic last);
      list_result_t exp_r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction: status=%0d pos=%0d len=%0d last=%0d",
                 $time, status, match_position, list_length, last);
        return;
      end
      exp_r = expected_results.pop_front();
      if (status !== exp_r.status || match_position !== exp_r.match_position ||
          list_length !== exp_r.list_length || last !== exp_r.last) begin
        errors++;
        $display("%0t: mismatch: expected status=%0d pos=%0d len=%0d last=%0d, got status=%0d pos=%0d len=%0d last=%0d",
                 $time, exp_r.status, exp_r.match_position, exp_r.list_length,
                 exp_r.last, status, match_position, list_length, last);
      end
    endfunction
  endclass

endpackage

[verif/tb_ordered_list_insert_delete_find.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete_find
// Drives insert, delete and find operations with random gaps and output
// stalls; a shadow list in the scoreboard predicts every result transaction.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_delete_find;

  import olidf_pkg::*;
  import olidf_tb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 2 * DEPTH + 10;

  logic clk;
  logic rst_n;

  olidf_in_if  in_chan ();
  olidf_out_if out_chan ();

  ordered_list_insert_delete_find dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  list_scoreboard          sb;
  bit                      steady;
  int                      rx_stall;
  int                      cycle_count;
  logic signed [VAL_W-1:0] value_pool [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_chan.ready <= 1'b0;
      rx_stall       <= rx_stall - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) rx_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.status, out_chan.match_position,
                      out_chan.list_length, out_chan.last);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL ordered_list_insert_delete_find");
    $finish;
  end

  // Called and returns at a falling edge.
  task automatic send_op(input logic [1:0] m, input logic [FLD_W-1:0] p,
                         input logic signed [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.mode     <= m;
    in_chan.position <= p;
    in_chan.value    <= v;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_op(m, p, v);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Phase 0 fills, phase 1 drains, phase 2 mixes.
  task automatic random_op(input int phase);
    int          r;
    int unsigned len;
    logic [1:0]  m;
    logic [4:0]  p;
    r   = $urandom_range(0, 99);
    len = sb.shadow_len;
    case (phase)
      0:       m = (r < 70) ? MODE_INSERT : (r < 90) ? MODE_FIND :
                   (r < 98) ? MODE_DELETE : MODE_UNUSED;
      1:       m = (r < 65) ? MODE_DELETE : (r < 90) ? MODE_FIND :
                   (r < 98) ? MODE_INSERT : MODE_UNUSED;
      default: m = (r < 35) ? MODE_INSERT : (r < 65) ? MODE_FIND :
                   (r < 98) ? MODE_DELETE : MODE_UNUSED;
    endcase
    if ($urandom_range(0, 99) < 85 && m == MODE_INSERT)
      p = FLD_W'($urandom_range(0, len + 1));
    else if ($urandom_range(0, 99) < 85 && m == MODE_DELETE)
      p = FLD_W'($urandom_range(1, (len > 0) ? len : 1));
    else
      p = FLD_W'($urandom_range(0, 31));
    send_op(m, p, pick_value());
  endtask

  initial begin
    logic signed [VAL_W-1:0] fill_val;
    int                      round;
    sb               = new();
    steady           = 1'b0;
    rx_stall         = 0;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.mode     = MODE_INSERT;
    in_chan.position = '0;
    in_chan.value    = '0;
    out_chan.ready   = 1'b0;
    value_pool[0]    = 32'sh7fffffff;
    value_pool[1]    = 32'sh80000000;
    value_pool[2]    = $urandom;
    value_pool[3]    = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty-list cases, head and tail inserts, bad positions, unused mode
    send_op(MODE_FIND,   5'd0,  32'sd5);
    send_op(MODE_DELETE, 5'd1,  32'sd0);
    send_op(MODE_INSERT, 5'd2,  32'sd1);
    send_op(MODE_INSERT, 5'd0,  32'sh7fffffff);
    send_op(MODE_INSERT, 5'd1,  32'sh80000000);
    send_op(MODE_INSERT, 5'd3,  -32'sd1);
    send_op(MODE_INSERT, 5'd31, 32'sd0);
    send_op(MODE_UNUSED, 5'd31, -32'sd1);
    send_op(MODE_INSERT, 5'd2,  -32'sd1);
    send_op(MODE_FIND,   5'd31, -32'sd1);
    send_op(MODE_FIND,   5'd0,  32'sh7fffffff);
    send_op(MODE_DELETE, 5'd0,  32'sd0);
    send_op(MODE_DELETE, 5'd5,  32'sd0);
    send_op(MODE_DELETE, 5'd4,  32'sd0);
    send_op(MODE_DELETE, 5'd1,  32'sd0);
    send_op(MODE_FIND,   5'd0,  32'sd0);
    send_op(MODE_DELETE, 5'd1,  32'sd0);
    send_op(MODE_DELETE, 5'd1,  32'sd0);
    wait_idle();

    // fill with one value: all-match find, full list, bad position when full
    fill_val = $urandom;
    while (sb.shadow_len < DEPTH)
      send_op(MODE_INSERT, FLD_W'($urandom_range(0, sb.shadow_len + 1)), fill_val);
    send_op(MODE_FIND,   5'd7,  fill_val);
    send_op(MODE_INSERT, 5'd17, 32'sd0);
    send_op(MODE_INSERT, 5'd18, 32'sd0);
    send_op(MODE_INSERT, 5'd0,  32'sd0);
    send_op(MODE_DELETE, 5'd16, 32'sd0);
    send_op(MODE_DELETE, 5'd16, 32'sd0);
    wait_idle();

    for (round = 0; round < 6; round++) begin
      steady = (round == 4);
      repeat (18) random_op(round % 3);
      wait_idle();
    end
    steady = 1'b0;

    wait_idle();
    if (sb.errors == 0) begin
      $display("PASS ordered_list_insert_delete_find");
    end else begin
      $display("FAIL ordered_list_insert_delete_find");
    end
    $finish;
  end

endmodule
